// ----- rtl/polynomial_bisection_root_finder_core_assert.svh -----
// Assertion macros used by the checker file
`ifndef POLYNOMIAL_BISECTION_ROOT_FINDER_CORE_ASSERT_SVH
`define POLYNOMIAL_BISECTION_ROOT_FINDER_CORE_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define PBR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pbr_pkg.sv -----
`default_nettype none
package pbr_pkg;

    localparam int unsigned SUBINTERVALS_DEF = 10;
    localparam int unsigned QUEUE_DEPTH      = 2;

    typedef struct packed {
        logic signed [31:0] bound_one;
        logic signed [31:0] bound_two;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] root;
        logic               found;
        logic               last;
    } out_item_t;

    // classified job handed from front to back
    typedef struct packed {
        logic signed [32:0] lo;
        logic        [32:0] h;
    } job_t;

    // sign of f(x) = x(x-1)(x+1)(x-2)(x+2): 1 = negative, 0 = positive or zero
    typedef struct packed {
        logic neg;
        logic zero;
    } fsign_t;

    function automatic fsign_t poly_sign(input logic signed [33:0] x);
        fsign_t s;
        logic [4:0] n;
        logic [4:0] z;
        logic signed [35:0] xe;
        xe = 36'(x);
        n[0] = xe < 0;
        z[0] = xe == 0;
        n[1] = xe < 36'sh1000000;
        z[1] = xe == 36'sh1000000;
        n[2] = xe < -36'sh1000000;
        z[2] = xe == -36'sh1000000;
        n[3] = xe < 36'sh2000000;
        z[3] = xe == 36'sh2000000;
        n[4] = xe < -36'sh2000000;
        z[4] = xe == -36'sh2000000;
        s.zero = |z;
        s.neg  = !s.zero && ^n;
        return s;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/pbr_front.sv -----
`default_nettype none
// Orders bounds and derives the step width by a two-part reciprocal multiply
module pbr_front #(
    parameter int unsigned SUBINTERVALS = pbr_pkg::SUBINTERVALS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire pbr_pkg::in_item_t item,
    output logic                 idle,
    output logic                 job_valid,
    output pbr_pkg::job_t        job,
    input  wire logic            job_ready
);
    // ceil(2^SH / SUBINTERVALS) gives an exact floor quotient for any 32-bit span
    localparam int unsigned SH = 32 + $clog2(SUBINTERVALS);
    localparam logic [63:0] RECIP =
        ((64'd1 << SH) + 64'(SUBINTERVALS) - 64'd1) / 64'(SUBINTERVALS);
    localparam logic [16:0] RECIP_LO = RECIP[16:0];
    localparam logic [15:0] RECIP_HI = RECIP[32:17];

    typedef enum logic [1:0] {S_IDLE, S_MUL_LO, S_MUL_HI, S_PUSH} state_t;

    state_t state_reg;
    logic [31:0] span_reg;
    logic [48:0] acc_reg;
    logic [32:0] quo_reg;
    logic signed [32:0] lo_reg;
    logic ordered;
    logic signed [32:0] lo_pick;
    logic signed [32:0] hi_pick;
    logic [32:0] span;
    logic [48:0] prod_lo;
    logic [47:0] prod_hi;
    logic [65:0] prod_sum;

    // ordered bounds and their distance
    assign ordered = item.bound_one < item.bound_two;
    assign lo_pick = ordered ? 33'(item.bound_one) : 33'(item.bound_two);
    assign hi_pick = ordered ? 33'(item.bound_two) : 33'(item.bound_one);
    assign span    = hi_pick - lo_pick;

    // partial products of span times reciprocal
    assign prod_lo  = span_reg * RECIP_LO;
    assign prod_hi  = span_reg * RECIP_HI;
    assign prod_sum = 66'(acc_reg) + 66'({prod_hi, 17'd0});

    assign idle = state_reg == S_IDLE;
    assign job_valid = state_reg == S_PUSH;
    assign job.lo = lo_reg;
    assign job.h  = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        lo_reg    <= lo_pick;
                        span_reg  <= span[31:0];
                        state_reg <= S_MUL_LO;
                    end
                end
                S_MUL_LO:
                begin
                    acc_reg   <= prod_lo;
                    state_reg <= S_MUL_HI;
                end
                S_MUL_HI:
                begin
                    quo_reg   <= 33'(prod_sum >> SH);
                    state_reg <= S_PUSH;
                end
                S_PUSH:
                begin
                    if (job_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/pbr_queue.sv -----
`default_nettype none
// Short job queue between front and back
module pbr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire pbr_pkg::job_t push_data,
    output logic               full,
    output logic               empty,
    input  wire logic          pop,
    output pbr_pkg::job_t      pop_data
);
    localparam int unsigned D  = pbr_pkg::QUEUE_DEPTH;
    localparam int unsigned AW = (D > 1) ? $clog2(D) : 1;

    pbr_pkg::job_t mem [D];
    logic [AW-1:0] wp_reg;
    logic [AW-1:0] rp_reg;
    logic [AW:0]   cnt_reg;

    assign full  = cnt_reg == (AW+1)'(D);
    assign empty = cnt_reg == '0;
    assign pop_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
                wp_reg <= (wp_reg == AW'(D - 1)) ? '0 : wp_reg + 1'b1;
            if (pop && !empty)
                rp_reg <= (rp_reg == AW'(D - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/pbr_back.sv -----
`default_nettype none
// Scans the grid and bisects each bracketing step
module pbr_back #(
    parameter int unsigned SUBINTERVALS = pbr_pkg::SUBINTERVALS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          job_valid,
    input  wire pbr_pkg::job_t job,
    output logic               job_pop,
    output logic               result_valid,
    output pbr_pkg::out_item_t result
);
    localparam int unsigned IW = $clog2(SUBINTERVALS + 1);

    typedef enum logic [2:0] {S_IDLE, S_GRID, S_BIS, S_EMIT, S_NONE} state_t;

    state_t state_reg;
    logic [IW-1:0] idx_reg;
    logic signed [33:0] left_reg;
    logic signed [33:0] right_reg;
    logic signed [33:0] mid_reg;
    logic signed [33:0] next_reg;
    logic signed [33:0] held_reg;
    logic [33:0] h_reg;
    logic found_reg;
    logic signed [33:0] mid;
    logic signed [33:0] width;
    pbr_pkg::fsign_t sl, sr, sm;

    assign width = right_reg - left_reg;
    assign mid = left_reg + (width >>> 1);
    assign sl = pbr_pkg::poly_sign(left_reg);
    assign sr = pbr_pkg::poly_sign(right_reg);
    assign sm = pbr_pkg::poly_sign(mid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            job_pop      <= 1'b0;
            result_valid <= 1'b0;
            idx_reg      <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            job_pop      <= 1'b0;
            result_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid && !job_pop)
                    begin
                        job_pop   <= 1'b1;
                        h_reg     <= 34'(job.h);
                        left_reg  <= 34'(job.lo);
                        right_reg <= 34'(job.lo) + 34'(job.h);
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        state_reg <= S_GRID;
                    end
                end
                S_GRID:
                begin
                    // test one step's ends
                    if (idx_reg == IW'(SUBINTERVALS))
                    begin
                        state_reg <= found_reg ? S_EMIT : S_NONE;
                    end
                    else if (sl.neg != sr.neg && !sl.zero && !sr.zero)
                    begin
                        // keep the step's right end to resume the scan
                        next_reg  <= right_reg;
                        state_reg <= S_BIS;
                    end
                    else
                    begin
                        left_reg  <= right_reg;
                        right_reg <= right_reg + h_reg;
                        idx_reg   <= idx_reg + 1'b1;
                    end
                end
                S_BIS:
                begin
                    // one bisection step a cycle
                    mid_reg <= mid;
                    if (!sl.zero && !sm.zero && sl.neg != sm.neg)
                    begin
                        right_reg <= mid;
                        if (mid - left_reg <= 34'sd1)
                            state_reg <= S_EMIT;
                    end
                    else
                    begin
                        left_reg <= mid;
                        if (right_reg - mid <= 34'sd1)
                            state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (idx_reg == IW'(SUBINTERVALS))
                    begin
                        // flush the held root as the final one
                        result_valid <= 1'b1;
                        result.root  <= held_reg[31:0];
                        result.found <= 1'b1;
                        result.last  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                    else
                    begin
                        // previous root, if any, goes out non-final
                        if (found_reg)
                        begin
                            result_valid <= 1'b1;
                            result.root  <= held_reg[31:0];
                            result.found <= 1'b1;
                            result.last  <= 1'b0;
                        end
                        held_reg  <= mid_reg;
                        found_reg <= 1'b1;
                        state_reg <= S_GRID;
                        idx_reg   <= idx_reg + 1'b1;
                        left_reg  <= next_reg;
                        right_reg <= next_reg + h_reg;
                    end
                end
                S_NONE:
                begin
                    result_valid <= 1'b1;
                    result.root  <= '0;
                    result.found <= 1'b0;
                    result.last  <= 1'b1;
                    state_reg    <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- rtl/polynomial_bisection_root_finder_core.sv -----
`default_nettype none
// The front end orders the bounds and forms the step width by reciprocal multiply;
// the back end then scans each grid step, bisects each bracketing step and emits
// one result per root found, or a single no-root result.
// The front end takes a new transaction only once its previous job has entered the
// queue; the back end works one transaction at a time.
// Results cannot be stalled. Reset (rst_n, async) clears all control state.
module polynomial_bisection_root_finder_core #(
    parameter int unsigned SUBINTERVALS = pbr_pkg::SUBINTERVALS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire pbr_pkg::in_item_t   item,
    output logic                     busy,
    output logic                     strobe,
    output pbr_pkg::out_item_t       result
);
    logic f_idle, f_valid, q_full, q_empty, b_pop;
    pbr_pkg::job_t f_job, q_job;

    assign busy = !f_idle;

    pbr_front #(.SUBINTERVALS(SUBINTERVALS)) u_front (
        .clk(clk), .rst_n(rst_n), .take(start && f_idle), .item(item),
        .idle(f_idle), .job_valid(f_valid), .job(f_job), .job_ready(!q_full)
    );

    pbr_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(f_valid), .push_data(f_job),
        .full(q_full), .empty(q_empty), .pop(b_pop), .pop_data(q_job)
    );

    pbr_back #(.SUBINTERVALS(SUBINTERVALS)) u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(!q_empty), .job(q_job),
        .job_pop(b_pop), .result_valid(strobe), .result(result)
    );
endmodule
`default_nettype wire

// ----- rtl/pbr_checker.sv -----
`default_nettype none
`include "polynomial_bisection_root_finder_core_assert.svh"
// Port-level checks on the root finder
module pbr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic               strobe,
    input wire pbr_pkg::out_item_t result
);
    `PBR_ASSERT_IMP(a_none_is_last, clk, rst_n, strobe && !result.found, result.last, "no-root result not final")
    `PBR_ASSERT_IMP(a_none_zero, clk, rst_n, strobe && !result.found, result.root == 0, "no-root result not zero")
    `PBR_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy, "accepted transaction did not raise busy")
endmodule

bind polynomial_bisection_root_finder_core pbr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .strobe(strobe), .result(result)
);
`default_nettype wire
